// ----- rtl/sntp_reply_checker_macros.svh -----
// Assertion helpers shared by the checker RTL.
`ifndef SNTP_REPLY_CHECKER_MACROS_SVH
`define SNTP_REPLY_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SRCHK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SRCHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srchk_pkg.sv -----
`default_nettype none

package srchk_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int TS_W      = 64;
    localparam int OUTCOME_W = 3;
    localparam int CAUSE_W   = 3;
    localparam int ACC_W     = 5;
    localparam int REJ_W     = 6;
    localparam int LEAP_W    = 2;
    localparam int STOP_W    = 44;
    localparam int DLSEC_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 44;
    localparam int IN_DATA_W  = 408;
    localparam int OUT_DATA_W = 272;

    // Commands
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOST  = 2'd2;

    // Outcomes
    localparam logic [OUTCOME_W-1:0] OUT_ACCEPTED = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DONE_OK  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_LATE     = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_TOO_MANY = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_INCONS   = 3'd5;
    localparam logic [OUTCOME_W-1:0] OUT_ALARM    = 3'd6;
    localparam logic [OUTCOME_W-1:0] OUT_IDLE     = 3'd7;

    // Reject causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_LOST    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LENGTH  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_COOKIE  = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_VERSION = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_MODE    = 3'd5;
    localparam logic [CAUSE_W-1:0] CAUSE_STRATUM = 3'd6;
    localparam logic [CAUSE_W-1:0] CAUSE_ZERO_TX = 3'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEPTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REJECTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ERROR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE    = 2'd3;

    // Register reset values
    localparam logic [ACC_W-1:0]   MAX_ACCEPTS_RST = 5'd25;
    localparam logic [ACC_W-1:0]   MAX_REJECTS_RST = 5'd25;
    localparam logic [STOP_W-1:0]  STOP_ERROR_RST  = 44'd429496730;
    localparam logic [DLSEC_W-1:0] DEADLINE_RST    = 8'd15;

    // Packet checks
    localparam logic [LEN_W-1:0]  LEN_MIN     = 7'd48;
    localparam logic [LEN_W-1:0]  LEN_MAX     = 7'd68;
    localparam logic [2:0]        VER_MIN     = 3'd1;
    localparam logic [2:0]        VER_MAX     = 3'd4;
    localparam logic [2:0]        MODE_SERVER = 3'd4;
    localparam logic [BYTE_W-1:0] STRATUM_MAX = 8'd14;
    localparam logic [LEAP_W-1:0] LEAP_ALARM  = 2'd3;

    // 3600 s in 32.32, and signed 64-bit limits
    localparam logic [TS_W-1:0] INSANE_ERROR = 64'd15461882265600;
    localparam logic [TS_W-1:0] SIGN64       = 64'h8000_0000_0000_0000;
    localparam logic [TS_W-1:0] MAXPOS64     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_SAT     = 5'd31;

    typedef struct packed {
        logic            pad;
        logic [TS_W-1:0] arrival_time;
        logic [TS_W-1:0] send_time;
        logic [TS_W-1:0] sent_cookie;
        logic [TS_W-1:0] echoed_cookie;
        logic [TS_W-1:0] server_transmit_time;
        logic [TS_W-1:0] server_receive_time;
        logic [BYTE_W-1:0] peer_stratum;
        logic [BYTE_W-1:0] header_byte;
        logic [LEN_W-1:0]  packet_length;
    } in_item_t;

    typedef struct packed {
        logic [LEAP_W-1:0] leap_status;
        logic [REJ_W-1:0]  rejected_so_far;
        logic [ACC_W-1:0]  accepted_so_far;
        logic [TS_W-1:0]   best_error_out;
        logic [TS_W-1:0]   best_offset_out;
        logic [TS_W-1:0]   sample_error;
        logic [TS_W-1:0]   sample_offset;
        logic [CAUSE_W-1:0] reject_cause;
    } out_item_t;

    // Floor halving of a two's complement value
    function automatic logic [TS_W-1:0] half_floor(input logic [TS_W-1:0] v);
        return {v[TS_W-1], v[TS_W-1:1]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sntp_reply_checker.sv -----
// Channel  | Signals                       | Carries
// s (in)   | s_tvalid s_tready s_tdata s_tuser | one received event per transaction
// m (out)  | m_tvalid m_tready m_tdata m_tuser | one verdict per input transaction
// cfg      | cfg_wr_en cfg_index cfg_wr_data   | register writes, no read-back
//
// Throughput: one transaction per cycle unless the output stalls. An accepted
// transaction loads the input register, and its verdict is then loaded into the
// verdict register and offered on m.
// The first stage forms the sample offset, the error bound and the packet
// checks; the second stage updates the session state and the verdict in one step.
// A stalled output holds its verdict while one more input waits in the input
// register; s_tready drops only when both are full.
// Reset clears the session and loads the register defaults; no clearing pass.
`default_nettype none
`include "sntp_reply_checker_macros.svh"

module sntp_reply_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // packet_length, header_byte, peer_stratum, server_receive_time,
    // server_transmit_time, echoed_cookie, sent_cookie, send_time, arrival_time
    input  wire logic [srchk_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  wire logic [srchk_pkg::CMD_W-1:0]         s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // reject_cause, sample_offset, sample_error, best_offset_out,
    // best_error_out, accepted_so_far, rejected_so_far, leap_status
    output logic [srchk_pkg::OUT_DATA_W-1:0]         m_tdata,
    // outcome
    output logic [srchk_pkg::OUTCOME_W-1:0]          m_tuser,
    input  wire logic                                cfg_wr_en,
    input  wire logic [srchk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srchk_pkg::CFG_DAT_W-1:0]     cfg_wr_data
);
    import srchk_pkg::*;

    // Configuration registers
    logic [ACC_W-1:0]   max_accepts_reg;
    logic [ACC_W-1:0]   max_rejects_reg;
    logic [STOP_W-1:0]  stop_error_reg;
    logic [DLSEC_W-1:0] deadline_sec_reg;

    // Session state
    logic               open_reg,      open_next;
    logic [TS_W-1:0]    best_off_reg,  best_off_next;
    logic [TS_W-1:0]    best_err_reg,  best_err_next;
    logic [ACC_W-1:0]   acc_cnt_reg,   acc_cnt_next;
    logic [REJ_W-1:0]   rej_cnt_reg,   rej_cnt_next;
    logic [TS_W-1:0]    deadline_reg,  deadline_next;

    // Input stage
    logic               in_valid_reg;
    logic [CMD_W-1:0]   p_cmd_reg;
    logic [TS_W-1:0]    p_t4_reg;
    logic [TS_W-1:0]    p_off_reg,     p_off_next;
    logic [TS_W-1:0]    p_err_reg,     p_err_next;
    logic [CAUSE_W-1:0] p_cause_reg,   p_cause_next;
    logic [LEAP_W-1:0]  p_leap_reg,    p_leap_next;
    logic [TS_W-1:0]    p_dl_reg,      p_dl_next;

    // Output stage
    logic               m_valid_reg;
    out_item_t          out_reg,       out_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;

    in_item_t           in_item;
    logic               s_accept;
    logic               advance;
    logic               load_out;
    logic [TS_W:0]      dl_sum;
    logic [2:0]         ver;
    logic [TS_W-1:0]    in_x;
    logic [TS_W-1:0]    in_y;
    logic [TS_W-1:0]    in_d;
    logic [TS_W:0]      err_wide;
    logic [TS_W-1:0]    err_sat;

    assign in_item  = in_item_t'(s_tdata);
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign load_out = in_valid_reg && advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);
    assign m_tuser  = outcome_reg;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accepts_reg  <= MAX_ACCEPTS_RST;
            max_rejects_reg  <= MAX_REJECTS_RST;
            stop_error_reg   <= STOP_ERROR_RST;
            deadline_sec_reg <= DEADLINE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAX_ACCEPTS: max_accepts_reg  <= cfg_wr_data[ACC_W-1:0];
                REG_MAX_REJECTS: max_rejects_reg  <= cfg_wr_data[ACC_W-1:0];
                REG_STOP_ERROR:  stop_error_reg   <= cfg_wr_data[STOP_W-1:0];
                REG_DEADLINE:    deadline_sec_reg <= cfg_wr_data[DLSEC_W-1:0];
            endcase
        end
    end

    // Classify the packet and form the saturated deadline
    assign ver    = in_item.header_byte[5:3];
    assign dl_sum = {1'b0, in_item.arrival_time}
                  + {(TS_W - DLSEC_W - 31)'(0), deadline_sec_reg, 32'd0};

    always_comb
    begin
        p_dl_next   = dl_sum[TS_W] ? {TS_W{1'b1}} : dl_sum[TS_W-1:0];
        p_leap_next = (s_tuser == CMD_REPLY) ? in_item.header_byte[7:6] : '0;

        // Sample offset and error bound of the reply, error saturated to 64 bits
        in_x = in_item.server_receive_time - in_item.send_time;
        in_y = in_item.server_transmit_time - in_item.arrival_time;
        in_d = half_floor(in_item.arrival_time - in_item.send_time);
        p_off_next = half_floor(in_x) + half_floor(in_y)
                   + {(TS_W-1)'(0), in_x[0] & in_y[0]};
        err_wide = {in_x[TS_W-1], in_x} - {in_y[TS_W-1], in_y};
        err_sat  = (err_wide[TS_W] != err_wide[TS_W-1])
                 ? (err_wide[TS_W] ? SIGN64 : MAXPOS64)
                 : err_wide[TS_W-1:0];
        p_err_next = ($signed(err_sat) < $signed(in_d)) ? in_d : err_sat;

        priority if (s_tuser == CMD_LOST)
            p_cause_next = CAUSE_LOST;
        else if (in_item.packet_length < LEN_MIN || in_item.packet_length > LEN_MAX)
            p_cause_next = CAUSE_LENGTH;
        else if (in_item.echoed_cookie != in_item.sent_cookie)
            p_cause_next = CAUSE_COOKIE;
        else if (ver < VER_MIN || ver > VER_MAX)
            p_cause_next = CAUSE_VERSION;
        else if (in_item.header_byte[2:0] != MODE_SERVER)
            p_cause_next = CAUSE_MODE;
        else if (in_item.peer_stratum > STRATUM_MAX)
            p_cause_next = CAUSE_STRATUM;
        else if (in_item.server_transmit_time == '0)
            p_cause_next = CAUSE_ZERO_TX;
        else
            p_cause_next = CAUSE_NONE;
    end

    // Input register: hold while the verdict stage is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_cmd_reg   <= s_tuser;
            p_t4_reg    <= in_item.arrival_time;
            p_off_reg   <= p_off_next;
            p_err_reg   <= p_err_next;
            p_cause_reg <= p_cause_next;
            p_leap_reg  <= p_leap_next;
            p_dl_reg    <= p_dl_next;
        end
    end

    // Verdict and session update
    logic [TS_W-1:0]  off;
    logic [TS_W-1:0]  err;
    logic [TS_W:0]    off_diff;
    logic [TS_W:0]    off_rev;
    logic [TS_W:0]    off_mag;
    logic [TS_W-1:0]  a_mag;
    logic [TS_W:0]    b_sum;
    logic             incons;
    logic [ACC_W-1:0] acc_inc;
    logic [REJ_W-1:0] rej_inc;
    logic [TS_W-1:0]  new_best_err;
    logic             stop_hit;

    always_comb
    begin
        off = p_off_reg;
        err = p_err_reg;

        acc_inc = (acc_cnt_reg == ACC_SAT) ? ACC_SAT : acc_cnt_reg + 1'b1;
        rej_inc = rej_cnt_reg + 1'b1;

        // Distance to the best offset, both directions formed side by side
        off_diff = {off[TS_W-1], off} - {best_off_reg[TS_W-1], best_off_reg};
        off_rev  = {best_off_reg[TS_W-1], best_off_reg} - {off[TS_W-1], off};
        off_mag  = off_diff[TS_W] ? off_rev : off_diff;
        a_mag    = (acc_cnt_reg == '0) ? '0 : off_mag[TS_W-1:0];
        b_sum    = {best_err_reg[TS_W-1], best_err_reg} + {err[TS_W-1], err};
        incons   = b_sum[TS_W] || (a_mag > b_sum[TS_W-1:0]);

        new_best_err = ($signed(err) < $signed(best_err_reg)) ? err : best_err_reg;
        stop_hit = new_best_err[TS_W-1]
                || (new_best_err <= {(TS_W-STOP_W)'(0), stop_error_reg})
                || (acc_inc >= max_accepts_reg);

        open_next     = open_reg;
        best_off_next = best_off_reg;
        best_err_next = best_err_reg;
        acc_cnt_next  = acc_cnt_reg;
        rej_cnt_next  = rej_cnt_reg;
        deadline_next = deadline_reg;
        outcome_next  = OUT_IDLE;
        out_next.reject_cause  = CAUSE_NONE;
        out_next.sample_offset = '0;
        out_next.sample_error  = '0;
        out_next.leap_status   = p_leap_reg;

        priority if (p_cmd_reg == CMD_START)
        begin
            open_next     = 1'b1;
            best_off_next = '0;
            best_err_next = INSANE_ERROR;
            acc_cnt_next  = '0;
            rej_cnt_next  = '0;
            deadline_next = p_dl_reg;
            outcome_next  = OUT_ACCEPTED;
        end
        else if (p_cmd_reg != CMD_REPLY && p_cmd_reg != CMD_LOST)
        begin
            outcome_next = OUT_IDLE;
        end
        else if (!open_reg)
        begin
            outcome_next = OUT_IDLE;
        end
        else if (p_t4_reg > deadline_reg)
        begin
            open_next    = 1'b0;
            outcome_next = OUT_LATE;
        end
        else if (p_cause_reg != CAUSE_NONE)
        begin
            rej_cnt_next          = rej_inc;
            out_next.reject_cause = p_cause_reg;
            if (rej_inc > {1'b0, max_rejects_reg})
            begin
                open_next    = 1'b0;
                outcome_next = OUT_TOO_MANY;
            end
            else
            begin
                outcome_next = OUT_REJECTED;
            end
        end
        else
        begin
            acc_cnt_next           = acc_inc;
            best_err_next          = new_best_err;
            best_off_next          = ($signed(err) < $signed(best_err_reg)) ? off
                                                                            : best_off_reg;
            out_next.sample_offset = off;
            out_next.sample_error  = err;
            if (incons)
            begin
                open_next    = 1'b0;
                outcome_next = OUT_INCONS;
            end
            else if (p_leap_reg == LEAP_ALARM)
            begin
                open_next    = 1'b0;
                outcome_next = OUT_ALARM;
            end
            else if (stop_hit)
            begin
                open_next    = 1'b0;
                outcome_next = OUT_DONE_OK;
            end
            else
            begin
                outcome_next = OUT_ACCEPTED;
            end
        end

        out_next.best_offset_out = best_off_next;
        out_next.best_error_out  = best_err_next;
        out_next.accepted_so_far = acc_cnt_next;
        out_next.rejected_so_far = rej_cnt_next;
    end

    // Advance session state on each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            best_off_reg <= '0;
            best_err_reg <= INSANE_ERROR;
            acc_cnt_reg  <= '0;
            rej_cnt_reg  <= '0;
            deadline_reg <= '0;
        end
        else if (load_out)
        begin
            open_reg     <= open_next;
            best_off_reg <= best_off_next;
            best_err_reg <= best_err_next;
            acc_cnt_reg  <= acc_cnt_next;
            rej_cnt_reg  <= rej_cnt_next;
            deadline_reg <= deadline_next;
        end
    end

    // Verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg     <= out_next;
            outcome_reg <= outcome_next;
        end
    end

    // Checks
    `SRCHK_ASSERT_NEXT(a_start_clears, load_out && p_cmd_reg == CMD_START,
        open_reg && acc_cnt_reg == '0 && rej_cnt_reg == '0, "start did not open a clean session")
    `SRCHK_ASSERT_NEXT(a_close_on_end,
        load_out && (outcome_next == OUT_DONE_OK || outcome_next == OUT_LATE ||
        outcome_next == OUT_TOO_MANY || outcome_next == OUT_INCONS ||
        outcome_next == OUT_ALARM), !open_reg, "ending verdict left the session open")
    `SRCHK_ASSERT_NOW(a_best_bounded, 1'b1,
        !($signed(best_err_reg) > $signed(INSANE_ERROR)), "best error above initial bound")
    `SRCHK_ASSERT_NOW(a_rej_bounded, 1'b1, rej_cnt_reg <= 6'd32, "reject count overran")
    `SRCHK_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg,
        "input stage dropped a stalled transaction")

endmodule

`default_nettype wire
